[design/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the CSV stream tokenizer
// Character codes, mode and token kind codes, the token and step record
// types passed from the classifier through the queue to the output stage.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_LAST = 2'd1;

  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_FIELD   = 2'd1;
  localparam logic [1:0] KIND_ROW     = 2'd2;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  col;
    logic [15:0] row;
    logic [15:0] len;
  } token_t;

  // Up to two tokens per input item: one from the byte, one from end of document
  typedef struct packed {
    logic   a_vld;
    token_t a;
    logic   b_vld;
    token_t b;
  } step_t;

endpackage

[design/cst_front.sv]
// ----------------------------------------------------------------------------
// cst_front: byte classifier
// Accepts one byte item per cycle unless the queue is full, keeps the quote,
// CR and counter state and builds a step record of up to two queued tokens.
// ----------------------------------------------------------------------------
module cst_front import cst_pkg::*; #(
  parameter int              MAX_COLUMNS   = 256,
  parameter longint unsigned MAX_ROWS      = 65536,
  parameter longint unsigned MAX_FIELD_LEN = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic [1:0] mode_i,
  input  logic       full_i,
  output logic       push_o,
  output step_t      step_o
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int LEN_W = $clog2(MAX_FIELD_LEN + 1);

  logic             iq_q, iq_d;
  logic             qp_q, qp_d;
  logic             crp_q, crp_d;
  logic             fb_q, fb_d;
  logic             rb_q, rb_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             skip, handled, content, take;
  step_t            step;

  function automatic token_t mk_tok(logic [1:0] kind, logic [7:0] data,
                                    logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                    logic [LEN_W-1:0] len);
    token_t t;
    t.kind = kind;
    t.data = data;
    t.col  = 8'(col);
    t.row  = 16'(row);
    t.len  = 16'(len);
    return t;
  endfunction

  assign take    = valid_i && ready_o;
  assign ready_o = !full_i;

  always_comb begin
    iq_d    = iq_q;
    qp_d    = qp_q;
    crp_d   = crp_q;
    fb_d    = fb_q;
    rb_d    = rb_q;
    col_d   = col_q;
    row_d   = row_q;
    len_d   = len_q;
    skip    = 1'b0;
    handled = 1'b0;
    content = 1'b0;
    step    = '0;
    if (mode_i == MODE_BYTE || mode_i == MODE_LAST) begin
      if (crp_d) begin
        crp_d = 1'b0;
        if (data_i == CH_LF) skip = 1'b1;
      end
      if (!skip) begin
        if (qp_d) begin
          qp_d = 1'b0;
          if (data_i == CH_QUOTE) begin
            content = 1'b1;
            handled = 1'b1;
          end else begin
            iq_d = 1'b0;
          end
        end
        if (!handled) begin
          if (iq_d) begin
            if (data_i == CH_QUOTE) qp_d = 1'b1;
            else content = 1'b1;
          end else if (data_i == CH_QUOTE && !fb_d) begin
            iq_d = 1'b1;
            fb_d = 1'b1;
            rb_d = 1'b1;
          end else if (data_i == CH_COMMA) begin
            step.a_vld = 1'b1;
            step.a     = mk_tok(KIND_FIELD, 8'h00, col_d, row_d, len_d);
            if (col_d != COL_W'(MAX_COLUMNS - 1)) col_d = col_d + 1'b1;
            len_d = '0;
            fb_d  = 1'b0;
            rb_d  = 1'b1;
          end else if (data_i == CH_LF || data_i == CH_CR) begin
            if (rb_d) begin
              step.a_vld = 1'b1;
              step.a     = mk_tok(KIND_ROW, 8'h00, col_d, row_d, len_d);
              if (row_d != ROW_W'(MAX_ROWS - 1)) row_d = row_d + 1'b1;
              col_d = '0;
              len_d = '0;
              fb_d  = 1'b0;
              rb_d  = 1'b0;
            end
            if (data_i == CH_CR) crp_d = 1'b1;
          end else begin
            content = 1'b1;
          end
        end
      end
      if (content) begin
        if (len_d != LEN_W'(MAX_FIELD_LEN)) len_d = len_d + 1'b1;
        fb_d       = 1'b1;
        rb_d       = 1'b1;
        step.a_vld = 1'b1;
        step.a     = mk_tok(KIND_CONTENT, data_i, col_d, row_d, len_d);
      end
    end
    if (mode_i != MODE_BYTE) begin
      if (rb_d) begin
        step.b_vld = 1'b1;
        step.b     = mk_tok(KIND_ROW, 8'h00, col_d, row_d, len_d);
      end
      iq_d  = 1'b0;
      qp_d  = 1'b0;
      crp_d = 1'b0;
      fb_d  = 1'b0;
      rb_d  = 1'b0;
      col_d = '0;
      row_d = '0;
      len_d = '0;
    end
  end

  assign push_o = take && (step.a_vld || step.b_vld);
  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_q  <= 1'b0;
      qp_q  <= 1'b0;
      crp_q <= 1'b0;
      fb_q  <= 1'b0;
      rb_q  <= 1'b0;
      col_q <= '0;
      row_q <= '0;
      len_q <= '0;
    end else if (take) begin
      iq_q  <= iq_d;
      qp_q  <= qp_d;
      crp_q <= crp_d;
      fb_q  <= fb_d;
      rb_q  <= rb_d;
      col_q <= col_d;
      row_q <= row_d;
      len_q <= len_d;
    end
  end

endmodule

[design/cst_queue.sv]
// ----------------------------------------------------------------------------
// cst_queue: step record queue
// Short first-in first-out store between the classifier and the output stage.
// ----------------------------------------------------------------------------
module cst_queue import cst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t step_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output step_t step_o
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  step_t            mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = cnt_q == CNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign step_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

[design/cst_back.sv]
// ----------------------------------------------------------------------------
// cst_back: token output stage
// Pops step records and sends their tokens one per cycle through an output
// register while the receiver is ready, marking the final token of each step.
// ----------------------------------------------------------------------------
module cst_back import cst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  step_t  step_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output token_t out_tok_o,
  output logic   out_last_o
);

  logic   out_vld_q;
  token_t out_q;
  logic   last_q;
  logic   sec_vld_q;
  token_t sec_q;
  logic   adv;

  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && !sec_vld_q && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sec_vld_q <= 1'b0;
      last_q    <= 1'b0;
      out_q     <= '0;
      sec_q     <= '0;
    end else if (adv) begin
      if (sec_vld_q) begin
        out_vld_q <= 1'b1;
        out_q     <= sec_q;
        last_q    <= 1'b1;
        sec_vld_q <= 1'b0;
      end else if (valid_i) begin
        out_vld_q <= 1'b1;
        if (step_i.a_vld) begin
          out_q     <= step_i.a;
          last_q    <= !step_i.b_vld;
          sec_vld_q <= step_i.b_vld;
          sec_q     <= step_i.b;
        end else begin
          out_q  <= step_i.b;
          last_q <= 1'b1;
        end
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_tok_o   = out_q;
  assign out_last_o  = last_q;

`ifndef SYNTHESIS
  a_sec_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_vld_q |-> out_vld_q) else $error("second token without first");
  a_not_last_has_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !last_q) |-> sec_vld_q) else $error("step ended without last");
`endif

endmodule

[design/csv_stream_tokenizer.sv]
// ----------------------------------------------------------------------------
// csv_stream_tokenizer: streaming CSV tokenizer
// Turns a byte stream into content, field end and row end tokens.
// ----------------------------------------------------------------------------
// Input channel s_axis: one document byte per item, tuser gives the mode
// (plain byte, last byte of document, end of document without a byte).
// Output channel m_axis: one token per item; tuser is the token kind, tdata
// carries content byte, column, row and field length, tlast marks the final
// token caused by an input item.
// Path: a token passes through the queue and then the output register before it
// appears on m_axis. Throughput: one byte per cycle while the queue is not full;
// a byte that ends a document after content yields two tokens, which leave the
// single output register one after the other. A four-entry queue sits between
// the classifier and the output register, so input is accepted while the
// receiver stalls until the queue fills; s_axis_tready then falls.
// Reset clears the parse state, counters and queue; the next byte starts a
// new document, as it also does after an end of document.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer import cst_pkg::*; #(
  parameter int              MAX_COLUMNS   = 256,
  parameter longint unsigned MAX_ROWS      = 65536,
  parameter longint unsigned MAX_FIELD_LEN = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic [1:0]  s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // content_byte, column_index, row_index, field_length
  output logic [1:0]  m_axis_tuser,  // token_kind
  output logic        m_axis_tlast   // last_of_step
);

  logic   push, full, q_valid, pop;
  step_t  push_step, q_step;
  token_t tok;

  cst_front #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .data_i (s_axis_tdata),
    .mode_i (s_axis_tuser),
    .full_i (full),
    .push_o (push),
    .step_o (push_step)
  );

  cst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .step_i (push_step),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .step_o (q_step)
  );

  cst_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .step_i     (q_step),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_tok_o  (tok),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {tok.len, tok.row, tok.col, tok.data};
  assign m_axis_tuser = tok.kind;

endmodule
